FILE: rtl/dnsmfe_pkg.sv
// shared constants and result type for the dns message field extractor
`default_nettype none

package dnsmfe_pkg;

   localparam logic [15:0] TypeAaaa    = 16'd28;
   localparam int          QrBit       = 7;
   localparam logic [4:0]  HeaderBytes = 5'd12;
   localparam logic [4:0]  AtypeSpan   = 5'd6;
   localparam logic [4:0]  AddrSpan    = 5'd24;
   localparam logic [4:0]  AddrBytes   = 5'd16;
   localparam logic [7:0]  DotChar     = 8'h2E;

   // one result produced by the parser for the byte just taken
   typedef struct packed {
      logic        emit;
      logic        kind;
      logic [7:0]  name_char;
      logic [15:0] ident;
      logic        is_response;
      logic [15:0] question_type;
      logic [15:0] answer_type;
      logic        is_ipv6;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [16:0] total_length;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/dnsmfe_parser.sv
// byte-wise parse state machine: header, question name, types and answer address
`default_nettype none

module dnsmfe_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             data_byte,
   output dnsmfe_pkg::result_type      result
);

   typedef enum logic [3:0] {
      PH_PFX_HI,
      PH_PFX_LO,
      PH_HDR,
      PH_NAME,
      PH_QTYPE,
      PH_ATYPE,
      PH_ADDR,
      PH_TAIL,
      PH_ADDR_DONE
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [15:0]   length_ff, length_in;
   logic [15:0]   seen_ff, seen_in;
   logic [4:0]    offset_ff, offset_in;
   logic [7:0]    held_ff, held_in;
   logic [15:0]   id_ff, id_in;
   logic          resp_ff, resp_in;
   logic [15:0]   qtype_ff, qtype_in;
   logic [15:0]   atype_ff, atype_in;
   logic [7:0]    label_ff, label_in;
   logic [127:0]  addr_ff, addr_in;

   logic          have_char;
   logic [7:0]    ch;
   logic          counted;
   logic          last;
   logic [15:0]   seen_inc;
   logic [4:0]    offset_inc;
   logic [15:0]   rel_type;

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      seen_in    = seen_ff;
      offset_in  = offset_ff;
      held_in    = held_ff;
      id_in      = id_ff;
      resp_in    = resp_ff;
      qtype_in   = qtype_ff;
      atype_in   = atype_ff;
      label_in   = label_ff;
      addr_in    = addr_ff;
      have_char  = 1'b0;
      ch         = 8'h00;
      counted    = 1'b1;
      last       = 1'b0;
      seen_inc   = seen_ff + 16'd1;
      offset_inc = offset_ff + 5'd1;

      unique case (phase_ff)
         PH_PFX_HI: begin
            length_in = {data_byte, 8'h00};
            phase_in  = PH_PFX_LO;
            counted   = 1'b0;
         end
         PH_PFX_LO: begin
            length_in = {length_ff[15:8], data_byte};
            seen_in   = 16'd0;
            offset_in = 5'd0;
            phase_in  = PH_HDR;
            counted   = 1'b0;
         end
         PH_HDR: begin
            if (offset_ff == 5'd1) begin
               id_in = {held_ff, data_byte};
            end else if (offset_ff == 5'd3) begin
               resp_in = held_ff[dnsmfe_pkg::QrBit];
            end
            offset_in = offset_inc;
            if (offset_inc >= dnsmfe_pkg::HeaderBytes) begin
               phase_in  = PH_NAME;
               offset_in = 5'd0;
               label_in  = 8'd0;
            end
         end
         PH_NAME: begin
            if (data_byte == 8'd0) begin
               phase_in  = PH_QTYPE;
               offset_in = 5'd0;
            end else if (label_ff == 8'd0) begin
               // label length byte: separator unless it is the first label
               if (offset_ff != 5'd0) begin
                  have_char = 1'b1;
                  ch        = dnsmfe_pkg::DotChar;
               end
               label_in  = data_byte;
               offset_in = 5'd1;
            end else begin
               have_char = 1'b1;
               ch        = data_byte;
               label_in  = label_ff - 8'd1;
               offset_in = 5'd1;
            end
         end
         PH_QTYPE: begin
            if (offset_ff == 5'd1) begin
               qtype_in  = {held_ff, data_byte};
               phase_in  = resp_ff ? PH_ATYPE : PH_TAIL;
               offset_in = 5'd0;
            end else begin
               offset_in = 5'd1;
            end
         end
         PH_ATYPE: begin
            offset_in = offset_inc;
            if (offset_inc >= dnsmfe_pkg::AtypeSpan) begin
               atype_in  = {held_ff, data_byte};
               phase_in  = PH_ADDR;
               offset_in = 5'd0;
            end
         end
         PH_ADDR: begin
            if (offset_ff >= (dnsmfe_pkg::AddrSpan - dnsmfe_pkg::AddrBytes)) begin
               addr_in = {addr_ff[119:0], data_byte};
            end
            offset_in = offset_inc;
            if (offset_inc >= dnsmfe_pkg::AddrSpan) begin
               phase_in  = PH_ADDR_DONE;
               offset_in = 5'd0;
            end
         end
         default: begin
         end
      endcase

      if (counted) begin
         held_in = data_byte;
         seen_in = seen_inc;
         last    = (seen_inc >= length_ff);
      end else if (phase_ff == PH_PFX_LO) begin
         last = (length_in == 16'd0);
      end
   end

   assign rel_type = resp_in ? atype_in : qtype_in;

   always_comb begin
      result = '0;
      if (last) begin
         result.emit          = 1'b1;
         result.kind          = 1'b1;
         result.ident         = id_in;
         result.is_response   = resp_in;
         result.question_type = qtype_in;
         result.answer_type   = atype_in;
         result.is_ipv6       = (rel_type == dnsmfe_pkg::TypeAaaa);
         if (phase_in == PH_ADDR_DONE) begin
            result.addr_high = addr_in[127:64];
            result.addr_low  = addr_in[63:0];
         end
         result.total_length  = {1'b0, length_in} + 17'd2;
      end else if (have_char) begin
         result.emit      = 1'b1;
         result.name_char = ch;
      end
   end

   always_ff @(posedge clock) begin
      // end of message returns every field to its idle value
      if (reset || (step && last)) begin
         phase_ff  <= PH_PFX_HI;
         length_ff <= 16'd0;
         seen_ff   <= 16'd0;
         offset_ff <= 5'd0;
         held_ff   <= 8'd0;
         id_ff     <= 16'd0;
         resp_ff   <= 1'b0;
         qtype_ff  <= 16'd0;
         atype_ff  <= 16'd0;
         label_ff  <= 8'd0;
         addr_ff   <= 128'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
         offset_ff <= offset_in;
         held_ff   <= held_in;
         id_ff     <= id_in;
         resp_ff   <= resp_in;
         qtype_ff  <= qtype_in;
         atype_ff  <= atype_in;
         label_ff  <= label_in;
         addr_ff   <= addr_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dns_message_field_extractor_core.sv
// top level: dns-over-tcp message parser with a registered result stage
// a result is registered and appears on rsp_ in the cycle after the byte transfer that causes it
// throughput: one byte per cycle while the result register is empty or draining
// at most one result per byte; the parse state advances on every req transfer
// reset: synchronous, active high; clears parse state and the result valid flag
`default_nettype none

module dns_message_field_extractor_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_kind,
   output logic [7:0]        rsp_name_char,
   output logic [15:0]       rsp_ident,
   output logic              rsp_is_response,
   output logic [15:0]       rsp_question_type,
   output logic [15:0]       rsp_answer_type,
   output logic              rsp_is_ipv6,
   output logic [63:0]       rsp_addr_high,
   output logic [63:0]       rsp_addr_low,
   output logic [16:0]       rsp_total_length
);

   dnsmfe_pkg::result_type result;
   dnsmfe_pkg::result_type rsp_ff;
   logic                   rsp_valid_ff;
   logic                   step;

   // take a byte whenever the result register is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   dnsmfe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_data_byte),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= result.emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_name_char     = rsp_ff.name_char;
   assign rsp_ident         = rsp_ff.ident;
   assign rsp_is_response   = rsp_ff.is_response;
   assign rsp_question_type = rsp_ff.question_type;
   assign rsp_answer_type   = rsp_ff.answer_type;
   assign rsp_is_ipv6       = rsp_ff.is_ipv6;
   assign rsp_addr_high     = rsp_ff.addr_high;
   assign rsp_addr_low      = rsp_ff.addr_low;
   assign rsp_total_length  = rsp_ff.total_length;

endmodule

`default_nettype wire

FILE: tb/dnsmfe_checker.sv
// checker for the dns field extractor: predicts each result from the byte transfers and compares
module dnsmfe_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_kind,
   input  wire logic [7:0]  rsp_name_char,
   input  wire logic [15:0] rsp_ident,
   input  wire logic        rsp_is_response,
   input  wire logic [15:0] rsp_question_type,
   input  wire logic [15:0] rsp_answer_type,
   input  wire logic        rsp_is_ipv6,
   input  wire logic [63:0] rsp_addr_high,
   input  wire logic [63:0] rsp_addr_low,
   input  wire logic [16:0] rsp_total_length,
   output int               fail_count,
   output int               pending_count,
   output int               byte_count,
   output int               char_count,
   output int               summary_count,
   output int               aaaa_count,
   output int               addr_count
);

   typedef enum logic [3:0] {
      AwaitLenHi, AwaitLenLo, InHeader, InName, InQtype, ToAtype, InAddr, InTail, AddrDone
   } parse_phase_type;

   parse_phase_type phase_q;
   logic [15:0]  msg_len;
   logic [15:0]  seen;
   logic [4:0]   offset_q;
   logic [7:0]   prev_byte;
   logic [15:0]  ident_q;
   logic         qr_q;
   logic [15:0]  qtype_q;
   logic [15:0]  atype_q;
   logic [7:0]   label_left;
   logic [127:0] addr_q;

   dnsmfe_pkg::result_type parsed_results[$];
   dnsmfe_pkg::result_type want_rsp;
   dnsmfe_pkg::result_type step_rsp;
   bit           step_emits;

   task automatic clear_parse();
      phase_q    = AwaitLenHi;
      msg_len    = '0;
      seen       = '0;
      offset_q   = '0;
      prev_byte  = '0;
      ident_q    = '0;
      qr_q       = 1'b0;
      qtype_q    = '0;
      atype_q    = '0;
      label_left = '0;
      addr_q     = '0;
   endtask

   task automatic summarize(output dnsmfe_pkg::result_type r);
      logic [15:0] rel;
      rel = qr_q ? atype_q : qtype_q;
      r = '0;
      r.emit          = 1'b1;
      r.kind          = 1'b1;
      r.ident         = ident_q;
      r.is_response   = qr_q;
      r.question_type = qtype_q;
      r.answer_type   = atype_q;
      r.is_ipv6       = (rel == dnsmfe_pkg::TypeAaaa);
      // address only counts once all of its bytes have gone by
      if (phase_q == AddrDone) begin
         r.addr_high = addr_q[127:64];
         r.addr_low  = addr_q[63:0];
      end
      r.total_length  = {1'b0, msg_len} + 17'd2;
   endtask

   task automatic extract_fields(input logic [7:0] b, output bit emits,
                                 output dnsmfe_pkg::result_type r);
      bit         have_char;
      logic [7:0] ch;
      emits     = 1'b0;
      r         = '0;
      have_char = 1'b0;
      ch        = '0;
      case (phase_q)
         AwaitLenHi: begin
            msg_len = {b, 8'h00};
            phase_q = AwaitLenLo;
         end
         AwaitLenLo: begin
            msg_len[7:0] = b;
            seen         = '0;
            offset_q     = '0;
            if (msg_len == 16'd0) begin
               summarize(r);
               emits = 1'b1;
               clear_parse();
            end else begin
               phase_q = InHeader;
            end
         end
         default: begin
            case (phase_q)
               InHeader: begin
                  if (offset_q == 5'd1) begin
                     ident_q = {prev_byte, b};
                  end else if (offset_q == 5'd3) begin
                     qr_q = prev_byte[dnsmfe_pkg::QrBit];
                  end
                  offset_q = offset_q + 5'd1;
                  if (offset_q >= dnsmfe_pkg::HeaderBytes) begin
                     phase_q    = InName;
                     offset_q   = '0;
                     label_left = '0;
                  end
               end
               InName: begin
                  // any zero ends the name, even in the middle of a label
                  if (b == 8'h00) begin
                     phase_q  = InQtype;
                     offset_q = '0;
                  end else if (label_left == 8'd0) begin
                     if (offset_q != 5'd0) begin
                        have_char = 1'b1;
                        ch        = dnsmfe_pkg::DotChar;
                     end
                     label_left = b;
                     offset_q   = 5'd1;
                  end else begin
                     have_char  = 1'b1;
                     ch         = b;
                     label_left = label_left - 8'd1;
                     offset_q   = 5'd1;
                  end
               end
               InQtype: begin
                  if (offset_q == 5'd1) begin
                     qtype_q  = {prev_byte, b};
                     phase_q  = qr_q ? ToAtype : InTail;
                     offset_q = '0;
                  end else begin
                     offset_q = 5'd1;
                  end
               end
               ToAtype: begin
                  offset_q = offset_q + 5'd1;
                  if (offset_q >= dnsmfe_pkg::AtypeSpan) begin
                     atype_q  = {prev_byte, b};
                     phase_q  = InAddr;
                     offset_q = '0;
                  end
               end
               InAddr: begin
                  // only the last sixteen bytes of the span are the address
                  if (offset_q >= dnsmfe_pkg::AddrSpan - dnsmfe_pkg::AddrBytes) begin
                     addr_q = {addr_q[119:0], b};
                  end
                  offset_q = offset_q + 5'd1;
                  if (offset_q >= dnsmfe_pkg::AddrSpan) begin
                     phase_q  = AddrDone;
                     offset_q = '0;
                  end
               end
               default: ;
            endcase
            prev_byte = b;
            seen      = seen + 16'd1;
            // the summary wins over a name character on the last byte
            if (seen >= msg_len) begin
               summarize(r);
               emits = 1'b1;
               clear_parse();
            end else if (have_char) begin
               r.emit      = 1'b1;
               r.name_char = ch;
               emits       = 1'b1;
            end
         end
      endcase
   endtask

   task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         parsed_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (parsed_results.size() == 0) begin
               $error("unexpected result transfer: kind %0d char %0h", rsp_kind, rsp_name_char);
               fail_count++;
            end else begin
               want_rsp = parsed_results.pop_front();
               check_field("kind", 64'(want_rsp.kind), 64'(rsp_kind));
               check_field("name_char", 64'(want_rsp.name_char), 64'(rsp_name_char));
               check_field("ident", 64'(want_rsp.ident), 64'(rsp_ident));
               check_field("is_response", 64'(want_rsp.is_response), 64'(rsp_is_response));
               check_field("question_type", 64'(want_rsp.question_type),
                           64'(rsp_question_type));
               check_field("answer_type", 64'(want_rsp.answer_type), 64'(rsp_answer_type));
               check_field("is_ipv6", 64'(want_rsp.is_ipv6), 64'(rsp_is_ipv6));
               check_field("addr_high", want_rsp.addr_high, rsp_addr_high);
               check_field("addr_low", want_rsp.addr_low, rsp_addr_low);
               check_field("total_length", 64'(want_rsp.total_length), 64'(rsp_total_length));
            end
         end
         if (req_valid && req_ready) begin
            byte_count++;
            extract_fields(req_data_byte, step_emits, step_rsp);
            if (step_emits) begin
               parsed_results.push_back(step_rsp);
               if (!step_rsp.kind) begin
                  char_count++;
               end else begin
                  summary_count++;
                  if (step_rsp.is_ipv6) aaaa_count++;
                  if (step_rsp.addr_high != '0 || step_rsp.addr_low != '0) addr_count++;
               end
            end
         end
      end
      pending_count = parsed_results.size();
   end

endmodule

FILE: tb/tb_dns_message_field_extractor_core.sv
// testbench top: feeds dns-over-tcp byte streams to the extractor and reports the verdict
module tb_dns_message_field_extractor_core;

   localparam logic [15:0] TypeA       = 16'd1;
   localparam logic [7:0]  NamePointer = 8'hC0;
   localparam logic [7:0]  QnameOffset = 8'h0C;
   localparam logic [7:0]  NameEnd     = 8'h00;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [7:0]  rsp_name_char;
   logic [15:0] rsp_ident;
   logic        rsp_is_response;
   logic [15:0] rsp_question_type;
   logic [15:0] rsp_answer_type;
   logic        rsp_is_ipv6;
   logic [63:0] rsp_addr_high;
   logic [63:0] rsp_addr_low;
   logic [16:0] rsp_total_length;

   int fail_count;
   int pending_count;
   int byte_count;
   int char_count;
   int summary_count;
   int aaaa_count;
   int addr_count;

   bit         idling_on = 1'b1;
   bit         long_hold = 1'b0;
   int         gap_odds  = 4;
   int         random_items;
   logic [7:0] msg_bytes[$];

   dns_message_field_extractor_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_name_char     (rsp_name_char),
      .rsp_ident         (rsp_ident),
      .rsp_is_response   (rsp_is_response),
      .rsp_question_type (rsp_question_type),
      .rsp_answer_type   (rsp_answer_type),
      .rsp_is_ipv6       (rsp_is_ipv6),
      .rsp_addr_high     (rsp_addr_high),
      .rsp_addr_low      (rsp_addr_low),
      .rsp_total_length  (rsp_total_length)
   );

   dnsmfe_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_name_char     (rsp_name_char),
      .rsp_ident         (rsp_ident),
      .rsp_is_response   (rsp_is_response),
      .rsp_question_type (rsp_question_type),
      .rsp_answer_type   (rsp_answer_type),
      .rsp_is_ipv6       (rsp_is_ipv6),
      .rsp_addr_high     (rsp_addr_high),
      .rsp_addr_low      (rsp_addr_low),
      .rsp_total_length  (rsp_total_length),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .byte_count        (byte_count),
      .char_count        (char_count),
      .summary_count     (summary_count),
      .aaaa_count        (aaaa_count),
      .addr_count        (addr_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] pick_type();
      case ($urandom_range(0, 2))
         0: return dnsmfe_pkg::TypeAaaa;
         1: return TypeA;
         default: return 16'($urandom());
      endcase
   endfunction

   // builds one prefixed message into msg_bytes; full_size forces the largest length
   task automatic build_message(input bit full_size);
      logic [7:0]  body[$];
      logic [15:0] len;
      logic [15:0] qt;
      logic [15:0] ans_type;
      int          labels;
      int          ll;
      int          i;
      bit          qr;
      body = {};
      if (!full_size && $urandom_range(0, 7) == 0) begin
         // noise under a short length prefix
         len = 16'($urandom_range(0, 40));
         repeat (len) body.push_back(8'($urandom()));
      end else begin
         qr = 1'($urandom_range(0, 1));
         repeat (2) body.push_back(8'($urandom()));
         body.push_back({qr, 7'($urandom())});
         repeat (9) body.push_back(8'($urandom()));
         labels = $urandom_range(0, 4);
         repeat (labels) begin
            ll = $urandom_range(1, 9);
            body.push_back(8'(ll));
            repeat (ll) begin
               // a rare zero ends the name inside a label
               if ($urandom_range(0, 59) == 0) begin
                  body.push_back(NameEnd);
               end else begin
                  body.push_back(8'($urandom_range(1, 255)));
               end
            end
         end
         body.push_back(NameEnd);
         qt = pick_type();
         body.push_back(qt[15:8]);
         body.push_back(qt[7:0]);
         if (qr || $urandom_range(0, 3) == 0) begin
            ans_type = pick_type();
            repeat (2) body.push_back(8'($urandom()));
            body.push_back(NamePointer);
            body.push_back(QnameOffset);
            body.push_back(ans_type[15:8]);
            body.push_back(ans_type[7:0]);
            // class, ttl, rdlength and the sixteen address bytes
            repeat (24) body.push_back(8'($urandom()));
         end
         repeat ($urandom_range(0, 3)) body.push_back(8'($urandom()));
         case ($urandom_range(0, 9))
            7, 8: len = 16'($urandom_range(1, body.size() - 1));
            9: len = 16'(body.size() - 1);
            default: len = 16'(body.size());
         endcase
         if (full_size) begin
            len = 16'hFFFF;
            while (body.size() < 65535) body.push_back(8'($urandom()));
         end
      end
      msg_bytes.push_back(len[15:8]);
      msg_bytes.push_back(len[7:0]);
      for (i = 0; i < len; i++) msg_bytes.push_back(body[i]);
   endtask

   task automatic send_byte(input logic [7:0] b);
      if (idling_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_message();
      while (msg_bytes.size() != 0) send_byte(msg_bytes.pop_front());
   endtask

   // result side: random stall bursts, one long hold-off, none in the last stretch
   initial begin
      int odds;
      odds = 4;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (idling_on && odds != 0 && $urandom_range(1, odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
         if ($urandom_range(0, 99) == 0) begin
            odds = $urandom_range(2, 8);
            if (odds == 2) odds = 0;
         end
      end
   end

   initial begin
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      reset         <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero length, a one-byte message, then a minimal AAAA query
      msg_bytes = {8'h00, 8'h00};
      send_message();
      msg_bytes = {8'h00, 8'h01, 8'hFF};
      send_message();
      msg_bytes = {8'h00, 8'd17, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41, NameEnd,
                   dnsmfe_pkg::TypeAaaa[15:8], dnsmfe_pkg::TypeAaaa[7:0]};
      send_message();

      long_hold = 1'b1;
      while (random_items < 860) begin
         if ($urandom_range(0, 3) == 0) begin
            gap_odds = 0;
         end else begin
            gap_odds = $urandom_range(3, 10);
         end
         build_message(1'b0);
         random_items += msg_bytes.size();
         send_message();
      end

      // last stretch at full rate
      idling_on = 1'b0;
      repeat (6) begin
         build_message(1'b0);
         send_message();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("run covered %0d byte transfers: %0d name characters, %0d message summaries",
               byte_count, char_count, summary_count);
      $display("%0d summaries flagged AAAA, %0d carried a captured address",
               aaaa_count, addr_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: dns_message_field_extractor_core.f
rtl/dnsmfe_pkg.sv
rtl/dnsmfe_parser.sv
rtl/dns_message_field_extractor_core.sv
tb/dnsmfe_checker.sv
tb/tb_dns_message_field_extractor_core.sv
